FILE: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and codes shared by the max-heap priority queue core.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 8;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [KEY_W-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] result_value;
        logic [1:0]              status;
        logic [COUNT_W-1:0]      count;
    } out_beat_t;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_UP_CHK  = 13'b0000000000010,
        S_UP_CMP  = 13'b0000000000100,
        S_UP_WR   = 13'b0000000001000,
        S_RD_ROOT = 13'b0000000010000,
        S_RD_LAST = 13'b0000000100000,
        S_DN_LOAD = 13'b0000001000000,
        S_DN_CHK  = 13'b0000010000000,
        S_DN_RDR  = 13'b0000100000000,
        S_DN_CMPR = 13'b0001000000000,
        S_DN_SWAP = 13'b0010000000000,
        S_DN_WR   = 13'b0100000000000,
        S_FIN     = 13'b1000000000000
    } state_t;

endpackage

FILE: rtl/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/max_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// Binary max-heap of signed 32-bit keys kept in one synchronous RAM.
//
// Input channel (in_valid/in_ready/in_data) takes one operation per beat:
// push, pop maximum or peek maximum. Output channel (out_valid/out_ready/
// out_data) returns exactly one beat per operation with the value, a status
// (ok, empty, full) and the element count after the operation.
// One operation is worked at a time; in_ready is high only while idle.
// The time to out_valid is set by the RAM read-compare loop of the sift:
//   push: per level climbed, read the parent, compare, and move it down,
//   then write the key; pop: read root and last element, then per level
//   read the children, compare, and move the larger one up, then write
//   the key; peek: read the root; refused or empty ops: no RAM access.
// The next operation is taken the cycle after the previous result is posted.
// Results sit in an output register; a stalled receiver holds the finished
// operation in its last state and the next item waits on in_ready.
// Reset clears the element count and the handshake state; RAM contents are
// never read before being written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core #(
    parameter int DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mhpq_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mhpq_pkg::out_beat_t out_data
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [AW-1:0]           best_idx_reg, best_idx_next;
    logic signed [KEY_W-1:0] best_val_reg, best_val_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] res_reg, res_next;
    logic [1:0]              status_reg, status_next;
    logic                    pop_reg, pop_next;
    logic                    out_valid_reg, out_valid_next;
    out_beat_t               out_reg, out_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [KEY_W-1:0]        ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [KEY_W-1:0]        ram_rdata;
    logic signed [KEY_W-1:0] rd_key;

    logic [AW-1:0]           pos_m1;
    logic [AW-1:0]           parent_idx;
    logic [CW-1:0]           count_m1;
    logic [AW-1:0]           last_idx;
    logic [AW+1:0]           left_ext;
    logic [AW+1:0]           right_ext;
    logic [AW+1:0]           count_ext;
    logic                    in_acc;

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key     = $signed(ram_rdata);
    assign pos_m1     = pos_reg - AW'(1);
    assign parent_idx = pos_m1 >> 1;
    assign count_m1   = count_reg - CW'(1);
    assign last_idx   = count_m1[AW-1:0];
    assign left_ext   = {1'b0, pos_reg, 1'b1};
    assign right_ext  = left_ext + (AW+2)'(1);
    assign count_ext  = (AW+2)'(count_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        pop_next       = pop_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = key_reg;
        ram_raddr      = pos_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    status_next = ST_OK;
                    pop_next    = (in_data.operation == OP_POP);
                    case (in_data.operation)
                        OP_PUSH:
                        begin
                            res_next = in_data.value;
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                key_next   = in_data.value;
                                pos_next   = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                                state_next = S_UP_CHK;
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next    = -KEY_W'(1);
                                status_next = ST_EMPTY;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_RD_ROOT;
                            end
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_UP_CHK:
            begin
                ram_raddr = parent_idx;
                if (pos_reg == '0)
                begin
                    state_next = S_UP_WR;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (key_reg > rd_key)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = ram_rdata;
                    pos_next   = parent_idx;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                ram_we     = 1'b1;
                state_next = S_FIN;
            end
            S_RD_ROOT:
            begin
                ram_raddr  = '0;
                state_next = S_RD_LAST;
            end
            S_RD_LAST:
            begin
                res_next  = rd_key;
                ram_raddr = last_idx;
                if (pop_reg)
                begin
                    state_next = S_DN_LOAD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_LOAD:
            begin
                key_next   = rd_key;
                count_next = count_m1;
                pos_next   = '0;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                ram_raddr = left_ext[AW-1:0];
                if (left_ext >= count_ext)
                begin
                    state_next = S_DN_WR;
                end
                else
                begin
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR:
            begin
                ram_raddr = right_ext[AW-1:0];
                if (rd_key > key_reg)
                begin
                    best_val_next = rd_key;
                    best_idx_next = left_ext[AW-1:0];
                end
                else
                begin
                    best_val_next = key_reg;
                    best_idx_next = pos_reg;
                end
                if (right_ext < count_ext)
                begin
                    state_next = S_DN_CMPR;
                end
                else
                begin
                    state_next = S_DN_SWAP;
                end
            end
            S_DN_CMPR:
            begin
                if (rd_key > best_val_reg)
                begin
                    best_val_next = rd_key;
                    best_idx_next = right_ext[AW-1:0];
                end
                state_next = S_DN_SWAP;
            end
            S_DN_SWAP:
            begin
                if (best_idx_reg == pos_reg)
                begin
                    state_next = S_DN_WR;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = best_val_reg;
                    pos_next   = best_idx_reg;
                    state_next = S_DN_CHK;
                end
            end
            S_DN_WR:
            begin
                ram_we     = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.result_value = res_reg;
                    out_next.status       = status_reg;
                    out_next.count        = COUNT_W'(count_reg);
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        key_reg      <= key_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
        pop_reg      <= pop_next;
        out_reg      <= out_next;
    end

endmodule
